// ===== sv/cpuu_pkg.sv =====
// cpuu_pkg: shared constants, codes and types for the cpu usage core
// no dependencies

package cpuu_pkg;

   localparam int MAX_CORES_DEF     = 64;
   localparam int HISTORY_DEPTH_DEF = 100;

   localparam logic [6:0] ACTIVE_RESET = 7'd64;
   localparam int         PCT_SCALE    = 100;
   localparam int         QW           = 7;
   localparam int         TICKW        = 64;
   localparam int         NUMW         = TICKW + QW;
   localparam int         NTERMS       = 8;
   localparam int         TICK_LSB     = 13;
   localparam int         REQ_DW       = 528;
   localparam int         RSP_DW       = 24;

   localparam logic [1:0] KIND_CORE = 2'd0;
   localparam logic [1:0] KIND_ALL  = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_DELTA,
      ST_BUSY,
      ST_MUL,
      ST_DIV,
      ST_UPDATE,
      ST_HMETA,
      ST_HADDR,
      ST_HREAD,
      ST_HDATA,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       csr_take;
      logic       sum_step;
      logic [2:0] sum_sel;
      logic       delta;
      logic       busy;
      logic       mul;
      logic       div_step;
      logic [2:0] div_sel;
      logic       update;
      logic       hist_addr;
      logic       hist_data;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] in_kind;
      logic       in_range;
      logic       out_free;
   } status_type;

endpackage

// ===== sv/cpuu_ram.sv =====
// cpuu_ram: generic single write, single read ram with registered read
// no dependencies

module cpuu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cpuu_ctrl.sv =====
// cpuu_ctrl: sequencing state machine of the cpu usage core
// depends on cpuu_pkg

module cpuu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  cpuu_pkg::status_type st,
   output cpuu_pkg::cmd_type    cmd
);

   cpuu_pkg::state_type state_ff, state_in;
   logic [2:0]          step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpuu_pkg::ST_IDLE;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      cmd         = '0;
      cmd.sum_sel = step_ff;
      cmd.div_sel = step_ff;
      req_tready  = 1'b0;
      csr_ready   = 1'b0;
      unique case (state_ff)
         cpuu_pkg::ST_IDLE: begin
            req_tready   = !reset;
            csr_ready    = !reset;
            cmd.csr_take = csr_valid && !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               step_in  = 3'd0;
               priority if (st.in_kind == cpuu_pkg::KIND_ALL) begin
                  state_in = cpuu_pkg::ST_SUM;
               end else if (st.in_kind == cpuu_pkg::KIND_CORE && st.in_range) begin
                  state_in = cpuu_pkg::ST_SUM;
               end else if (st.in_kind == cpuu_pkg::KIND_READ && st.in_range) begin
                  state_in = cpuu_pkg::ST_HMETA;
               end else begin
                  state_in = cpuu_pkg::ST_DONE;
               end
            end
         end
         cpuu_pkg::ST_SUM: begin
            cmd.sum_step = 1'b1;
            step_in      = step_ff + 3'd1;
            if (step_ff == 3'(cpuu_pkg::NTERMS - 1)) begin
               state_in = cpuu_pkg::ST_DELTA;
            end
         end
         cpuu_pkg::ST_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = cpuu_pkg::ST_BUSY;
         end
         cpuu_pkg::ST_BUSY: begin
            cmd.busy = 1'b1;
            state_in = cpuu_pkg::ST_MUL;
         end
         cpuu_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            step_in  = 3'(cpuu_pkg::QW - 1);
            state_in = cpuu_pkg::ST_DIV;
         end
         cpuu_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               state_in = cpuu_pkg::ST_UPDATE;
            end
         end
         cpuu_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = cpuu_pkg::ST_DONE;
         end
         cpuu_pkg::ST_HMETA: begin
            state_in = cpuu_pkg::ST_HADDR;
         end
         cpuu_pkg::ST_HADDR: begin
            cmd.hist_addr = 1'b1;
            state_in      = cpuu_pkg::ST_HREAD;
         end
         cpuu_pkg::ST_HREAD: begin
            state_in = cpuu_pkg::ST_HDATA;
         end
         cpuu_pkg::ST_HDATA: begin
            cmd.hist_data = 1'b1;
            state_in      = cpuu_pkg::ST_DONE;
         end
         cpuu_pkg::ST_DONE: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = cpuu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cpuu_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/cpuu_dp.sv =====
// cpuu_dp: sums, deltas, percent divider, per-core stores and result register
// depends on cpuu_pkg and cpuu_ram

module cpuu_dp #(
   parameter int MAX_CORES     = cpuu_pkg::MAX_CORES_DEF,
   parameter int HISTORY_DEPTH = cpuu_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  req_tuser,
   input  logic [cpuu_pkg::REQ_DW-1:0] req_tdata,
   input  logic [6:0]                  csr_data,
   input  cpuu_pkg::cmd_type           cmd,
   output cpuu_pkg::status_type        st,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cpuu_pkg::RSP_DW-1:0] rsp_tdata,
   output logic                        rsp_tuser
);

   localparam int CW   = MAX_CORES > 1 ? $clog2(MAX_CORES) : 1;
   localparam int CNTW = $clog2(HISTORY_DEPTH + 1);
   localparam int HDW  = HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SDEP = MAX_CORES * HISTORY_DEPTH;
   localparam int SAW  = SDEP > 1 ? $clog2(SDEP) : 1;
   localparam int IXW  = 10;
   localparam int TW   = cpuu_pkg::TICKW;

   logic [1:0]      kind_ff;
   logic [CW-1:0]   core_ff;
   logic [6:0]      hidx_ff;
   logic [TW-1:0]   term_ff [cpuu_pkg::NTERMS];
   logic [TW-1:0]   idle_ff, total_ff, dt_ff, di_ff, busy_ff;
   logic            f_gt_ff, f_nz_ff, f_ige_ff, f_le_ff;
   logic [cpuu_pkg::NUMW-1:0] rem_ff;
   logic [cpuu_pkg::QW-1:0]   q_ff;
   logic [SAW-1:0]  base_ff, raddr_ff;
   logic            hit_ff;
   logic [TW-1:0]   all_tot_ff, all_idle_ff;
   logic [6:0]      all_usage_ff;
   logic [6:0]      active_ff;
   logic [MAX_CORES-1:0] prev_vld_ff, hist_vld_ff;
   logic [6:0]      res_value_ff, res_held_ff;
   logic            res_valid_ff;
   logic            rsp_valid_ff;
   logic [6:0]      out_value_ff, out_held_ff, out_all_ff;
   logic            out_valid_ff;

   logic [2*TW-1:0]       prev_rdata;
   logic [CNTW+HDW-1:0]   meta_rdata, meta_wdata;
   logic [6:0]            store_rdata;
   logic [TW-1:0]         ptot, pidle;
   logic [CNTW-1:0]       cnt, new_cnt;
   logic [HDW-1:0]        head, new_head;
   logic [CNTW:0]         wsum;
   logic [HDW-1:0]        wpos;
   logic [IXW-1:0]        rsum;
   logic [HDW-1:0]        rpos;
   logic [cpuu_pkg::NUMW-1:0] trial;
   logic                  ok_core, ok_all, push;
   logic [5:0]            in_core;

   assign in_core    = req_tdata[5:0];
   assign st.in_kind = req_tuser;
   assign st.in_range = (9'(in_core) < 9'(active_ff)) && (9'(in_core) < 9'(MAX_CORES));
   assign st.out_free = !rsp_valid_ff || rsp_tready;

   assign ptot  = (kind_ff == cpuu_pkg::KIND_ALL) ? all_tot_ff :
                  (prev_vld_ff[core_ff] ? prev_rdata[TW-1:0] : '0);
   assign pidle = (kind_ff == cpuu_pkg::KIND_ALL) ? all_idle_ff :
                  (prev_vld_ff[core_ff] ? prev_rdata[2*TW-1:TW] : '0);
   assign cnt   = hist_vld_ff[core_ff] ? meta_rdata[CNTW+HDW-1:HDW] : '0;
   assign head  = hist_vld_ff[core_ff] ? meta_rdata[HDW-1:0] : '0;

   // ring positions of the next write and of the history read
   assign wsum = (CNTW+1)'(head) + (CNTW+1)'(cnt);
   assign wpos = (wsum >= (CNTW+1)'(HISTORY_DEPTH)) ?
                 HDW'(wsum - (CNTW+1)'(HISTORY_DEPTH)) : HDW'(wsum);
   assign rsum = IXW'(head) + IXW'(hidx_ff);
   assign rpos = (rsum >= IXW'(HISTORY_DEPTH)) ?
                 HDW'(rsum - IXW'(HISTORY_DEPTH)) : HDW'(rsum);

   always_comb begin
      if (cnt < CNTW'(HISTORY_DEPTH)) begin
         new_cnt  = cnt + CNTW'(1);
         new_head = head;
      end else begin
         new_cnt  = cnt;
         new_head = (head == HDW'(HISTORY_DEPTH - 1)) ? '0 : head + HDW'(1);
      end
   end

   assign meta_wdata = {new_cnt, new_head};
   assign ok_core    = f_nz_ff && f_gt_ff;
   assign ok_all     = ok_core && f_ige_ff && f_le_ff;
   assign push       = cmd.update && kind_ff == cpuu_pkg::KIND_CORE && ok_core;
   assign trial      = cpuu_pkg::NUMW'(dt_ff) << cmd.div_sel;

   cpuu_ram #(.WIDTH(2 * TW), .DEPTH(MAX_CORES)) u_prev (
      .clock   (clock),
      .wr_en   (cmd.update && kind_ff == cpuu_pkg::KIND_CORE),
      .wr_addr (core_ff),
      .wr_data ({idle_ff, total_ff}),
      .rd_addr (core_ff),
      .rd_data (prev_rdata)
   );

   cpuu_ram #(.WIDTH(CNTW + HDW), .DEPTH(MAX_CORES)) u_meta (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (core_ff),
      .wr_data (meta_wdata),
      .rd_addr (core_ff),
      .rd_data (meta_rdata)
   );

   cpuu_ram #(.WIDTH(7), .DEPTH(SDEP)) u_store (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (base_ff + SAW'(wpos)),
      .wr_data (q_ff),
      .rd_addr (raddr_ff),
      .rd_data (store_rdata)
   );

   always_ff @(posedge clock) begin
      base_ff <= SAW'(SAW'(core_ff) * SAW'(HISTORY_DEPTH));
      if (cmd.load) begin
         kind_ff  <= req_tuser;
         core_ff  <= CW'(in_core);
         hidx_ff  <= req_tdata[12:6];
         for (int i = 0; i < cpuu_pkg::NTERMS; i++) begin
            term_ff[i] <= req_tdata[cpuu_pkg::TICK_LSB + TW*i +: TW];
         end
         idle_ff  <= req_tdata[cpuu_pkg::TICK_LSB + TW*3 +: TW]
                   + req_tdata[cpuu_pkg::TICK_LSB + TW*4 +: TW];
         total_ff <= '0;
         res_value_ff <= '0;
         res_valid_ff <= 1'b0;
         res_held_ff  <= '0;
      end
      if (cmd.sum_step) begin
         total_ff <= total_ff + term_ff[cmd.sum_sel];
      end
      if (cmd.delta) begin
         dt_ff    <= total_ff - ptot;
         di_ff    <= idle_ff - pidle;
         f_gt_ff  <= total_ff > ptot;
         f_nz_ff  <= ptot != '0;
         f_ige_ff <= idle_ff >= pidle;
      end
      if (cmd.busy) begin
         f_le_ff <= di_ff <= dt_ff;
         busy_ff <= (di_ff <= dt_ff) ? dt_ff - di_ff : '0;
      end
      if (cmd.mul) begin
         rem_ff <= cpuu_pkg::NUMW'(busy_ff) * cpuu_pkg::NUMW'(cpuu_pkg::PCT_SCALE);
         q_ff   <= '0;
      end
      // restoring division, one quotient bit per cycle
      if (cmd.div_step && rem_ff >= trial) begin
         rem_ff           <= rem_ff - trial;
         q_ff[cmd.div_sel] <= 1'b1;
      end
      if (cmd.update) begin
         if (kind_ff == cpuu_pkg::KIND_CORE) begin
            res_value_ff <= ok_core ? q_ff : '0;
            res_valid_ff <= ok_core;
            res_held_ff  <= ok_core ? 7'(new_cnt) : 7'(cnt);
         end else begin
            res_value_ff <= ok_all ? q_ff : '0;
            res_valid_ff <= ok_all;
         end
      end
      if (cmd.hist_addr) begin
         raddr_ff <= base_ff + SAW'(rpos);
         hit_ff   <= IXW'(hidx_ff) < IXW'(cnt);
         res_held_ff <= 7'(cnt);
      end
      if (cmd.hist_data) begin
         res_value_ff <= hit_ff ? store_rdata : '0;
         res_valid_ff <= hit_ff;
      end
      if (cmd.emit) begin
         out_value_ff <= res_value_ff;
         out_valid_ff <= res_valid_ff;
         out_held_ff  <= res_held_ff;
         out_all_ff   <= all_usage_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= cpuu_pkg::ACTIVE_RESET;
         prev_vld_ff  <= '0;
         hist_vld_ff  <= '0;
         all_usage_ff <= '0;
         rsp_valid_ff <= 1'b0;
         all_tot_ff   <= '0;
         all_idle_ff  <= '0;
      end else begin
         if (cmd.csr_take) begin
            active_ff <= csr_data;
            if (csr_data != active_ff) begin
               prev_vld_ff <= '0;
            end
         end
         if (cmd.update && kind_ff == cpuu_pkg::KIND_CORE) begin
            prev_vld_ff[core_ff] <= 1'b1;
         end
         if (push) begin
            hist_vld_ff[core_ff] <= 1'b1;
         end
         if (cmd.update && kind_ff == cpuu_pkg::KIND_ALL) begin
            all_tot_ff  <= total_ff;
            all_idle_ff <= idle_ff;
            if (ok_all) begin
               all_usage_ff <= q_ff;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_all_ff, out_held_ff, out_value_ff};
   assign rsp_tuser  = out_valid_ff;

endmodule

// ===== sv/cpu_usage_from_tick_counters_core.sv =====
// cpu_usage_from_tick_counters_core: top level, per-core and aggregate cpu usage
// depends on cpuu_pkg, cpuu_ctrl, cpuu_dp, cpuu_ram
//
//   group  direction  tdata / data                               tuser
//   req    in         core, hist index, eight 64-bit tick counts  kind
//   rsp    out        usage value, entries held, overall usage    usage valid
//   csr    in         active core count (7 bits)                  -
//
// a sample runs the counter sum through one adder, then the deltas, a 64x7
// multiply and a restoring divider; a history read goes through the history
// ram's registered read port.
// reset is synchronous; no clearing pass is needed (valid bits per core).
// a finished result waits in the output register while rsp_tready is low.

module cpu_usage_from_tick_counters_core #(
   parameter int MAX_CORES     = cpuu_pkg::MAX_CORES_DEF,
   parameter int HISTORY_DEPTH = cpuu_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [5:0] core_index, [12:6] history_index, then user, nice, system, idle,
   // iowait, irq, softirq, steal ticks 64 bits each from bit 13, zero pad
   input  logic [cpuu_pkg::REQ_DW-1:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [6:0] usage_value, [13:7] entries_held, [20:14] overall_usage, zero pad
   output logic [cpuu_pkg::RSP_DW-1:0] rsp_tdata,
   // [0] usage_valid
   output logic                        rsp_tuser,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [6:0]                  csr_data
);

   cpuu_pkg::cmd_type    cmd;
   cpuu_pkg::status_type st;

   cpuu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .st         (st),
      .cmd        (cmd)
   );

   cpuu_dp #(.MAX_CORES(MAX_CORES), .HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("transfer taken while busy");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] <= 7'd100 && rsp_tdata[20:14] <= 7'd100)
      else $error("usage out of range");

   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[6:0] == 7'd0)
      else $error("usage value without valid");

endmodule
